/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the matrix product unit
// Concurrent checks, sampled at the rising clock edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define MM4_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition must never be seen outside reset.
`define MM4_NEVER(label, clk, rst, cond, msg) \
   `MM4_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* hw/rtl/mm4_pkg.sv */
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

   localparam int DIM             = 4;
   localparam int ROW_W           = $clog2(DIM);
   localparam int DATA_W          = 32;
   localparam int PROD_W          = 2 * DATA_W;
   localparam int SUM_W           = PROD_W + $clog2(DIM);
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_MUL  = 1'b1
   } op_type;

   typedef logic [DIM-1:0][DATA_W-1:0] row_type;

   typedef struct packed {
      op_type             op;
      logic [ROW_W-1:0]   row;
      row_type            elems;
   } entry_type;

endpackage

`default_nettype wire

/* hw/rtl/mm4_ifs.sv */
// ----------------------------------------------------------------------------
// mm4 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm4_req_if;
   import mm4_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [ROW_W-1:0]         row_index;
   logic signed [DATA_W-1:0] in_e0;
   logic signed [DATA_W-1:0] in_e1;
   logic signed [DATA_W-1:0] in_e2;
   logic signed [DATA_W-1:0] in_e3;

   modport source (output valid, req_type, row_index, in_e0, in_e1, in_e2, in_e3,
                   input ready);
   modport sink   (input valid, req_type, row_index, in_e0, in_e1, in_e2, in_e3,
                   output ready);
endinterface

interface mm4_rsp_if;
   import mm4_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         out_row;
   logic signed [DATA_W-1:0] out_e0;
   logic signed [DATA_W-1:0] out_e1;
   logic signed [DATA_W-1:0] out_e2;
   logic signed [DATA_W-1:0] out_e3;
   logic                     saturated;

   modport source (output valid, out_row, out_e0, out_e1, out_e2, out_e3, saturated,
                   input ready);
   modport sink   (input valid, out_row, out_e0, out_e1, out_e2, out_e3, saturated,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/mm4_front.sv */
// ----------------------------------------------------------------------------
// mm4_front
// Accepts request beats, classifies them as load or multiply and registers
// them toward the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_front (
   input  wire logic               clock,
   input  wire logic               reset,
   mm4_req_if.sink                 req,
   output logic                    push_vld,
   input  wire logic               push_rdy,
   output mm4_pkg::entry_type      push_data
);
   import mm4_pkg::*;

   logic      vld_ff;
   logic      vld_in;
   logic      accept;
   entry_type entry_ff;
   entry_type entry_in;

   // Take a new beat whenever the holding register is empty or draining.
   assign req.ready = !vld_ff || push_rdy;
   assign accept    = req.valid && req.ready;

   always_comb begin
      entry_in.op       = req.req_type ? OP_MUL : OP_LOAD;
      entry_in.row      = req.row_index;
      entry_in.elems[0] = req.in_e0;
      entry_in.elems[1] = req.in_e1;
      entry_in.elems[2] = req.in_e2;
      entry_in.elems[3] = req.in_e3;

      if (accept) begin
         vld_in = 1'b1;
      end else if (push_rdy) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_vld  = vld_ff;
   assign push_data = entry_ff;

endmodule

`default_nettype wire

/* hw/rtl/mm4_fifo.sv */
// ----------------------------------------------------------------------------
// mm4_fifo
// Short in-order work queue between front and back; decouples their stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mm4_fifo #(
   parameter int DEPTH = mm4_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_vld,
   output logic                    push_rdy,
   input  wire mm4_pkg::entry_type push_data,
   output logic                    pop_vld,
   input  wire logic               pop_rdy,
   output mm4_pkg::entry_type      pop_data
);
   import mm4_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_rdy = count_ff != CNT_W'(DEPTH);
   assign pop_vld  = count_ff != '0;
   assign push     = push_vld && push_rdy;
   assign pop      = pop_vld && pop_rdy;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MM4_ASSERT(a_fifo_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue over depth")
   `MM4_NEVER(a_fifo_ptr_skew, clock, reset, (count_ff == '0) && (wr_ptr_ff != rd_ptr_ff), "empty queue with skewed pointers")

endmodule

`default_nettype wire

/* hw/rtl/mm4_back.sv */
// ----------------------------------------------------------------------------
// mm4_back
// Executes queued beats in order: loads write a row of the B store, multiplies
// run through multiply, sum and shift/saturate stages into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mm4_back #(
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_vld,
   output logic                    pop_rdy,
   input  wire mm4_pkg::entry_type pop_data,
   mm4_rsp_if.source               rsp
);
   import mm4_pkg::*;

   // Pipeline advances as a whole whenever the output register can take a beat.
   logic                     pipe_adv;

   logic                     s0_vld_ff;
   entry_type                s0_ff;
   logic                     s0_load;
   logic                     s0_mul;

   logic [DATA_W-1:0]        b_ff [DIM][DIM];

   logic signed [PROD_W-1:0] prod_in [DIM][DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM][DIM];
   logic                     s1_vld_ff;
   logic [ROW_W-1:0]         s1_row_ff;

   logic signed [SUM_W-1:0]  sum_in [DIM];
   logic signed [SUM_W-1:0]  sum_ff [DIM];
   logic                     s2_vld_ff;
   logic [ROW_W-1:0]         s2_row_ff;

   logic signed [SUM_W-1:0]  shifted [DIM];
   logic [SUM_W-DATA_W:0]    shifted_hi [DIM];
   logic [DIM-1:0]           fits;
   logic [DATA_W-1:0]        elem_in [DIM];
   logic [DATA_W-1:0]        elem_ff [DIM];
   logic                     sat_in;
   logic                     sat_ff;
   logic [ROW_W-1:0]         row_ff;
   logic                     out_vld_ff;

   assign pipe_adv = !out_vld_ff || rsp.ready;
   assign pop_rdy  = pipe_adv;
   assign s0_load  = s0_vld_ff && (s0_ff.op == OP_LOAD);
   assign s0_mul   = s0_vld_ff && (s0_ff.op == OP_MUL);

   // Stage 0: registered queue head.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         s0_vld_ff <= pop_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && pop_vld) begin
         s0_ff <= pop_data;
      end
   end

   // B store: a load retires here, so a multiply behind it sees the new row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               b_ff[r][c] <= '0;
            end
         end
      end else if (pipe_adv && s0_load) begin
         for (int c = 0; c < DIM; c++) begin
            b_ff[s0_ff.row][c] <= s0_ff.elems[c];
         end
      end
   end

   // Stage 1: sixteen 32x32 signed products.
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int c = 0; c < DIM; c++) begin
            prod_in[k][c] = PROD_W'($signed(s0_ff.elems[k])) * PROD_W'($signed(b_ff[k][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_vld_ff <= s0_mul;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s0_mul) begin
         prod_ff   <= prod_in;
         s1_row_ff <= s0_ff.row;
      end
   end

   // Stage 2: exact column sums.
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         sum_in[c] = '0;
         for (int k = 0; k < DIM; k++) begin
            sum_in[c] = sum_in[c] + SUM_W'(prod_ff[k][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s1_vld_ff) begin
         sum_ff    <= sum_in;
         s2_row_ff <= s1_row_ff;
      end
   end

   // Stage 3: floor shift, then clip to 32 bits when the upper bits disagree.
   always_comb begin
      sat_in = 1'b0;
      for (int c = 0; c < DIM; c++) begin
         shifted[c]    = sum_ff[c] >>> FRAC_BITS;
         shifted_hi[c] = shifted[c][SUM_W-1:DATA_W-1];
         fits[c]       = (&shifted_hi[c]) || !(|shifted_hi[c]);
         if (fits[c]) begin
            elem_in[c] = shifted[c][DATA_W-1:0];
         end else if (sum_ff[c][SUM_W-1]) begin
            elem_in[c] = ELEM_MIN;
         end else begin
            elem_in[c] = ELEM_MAX;
         end
         sat_in = sat_in || !fits[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         out_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s2_vld_ff) begin
         elem_ff <= elem_in;
         sat_ff  <= sat_in;
         row_ff  <= s2_row_ff;
      end
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.out_row   = row_ff;
   assign rsp.out_e0    = elem_ff[0];
   assign rsp.out_e1    = elem_ff[1];
   assign rsp.out_e2    = elem_ff[2];
   assign rsp.out_e3    = elem_ff[3];
   assign rsp.saturated = sat_ff;

   `MM4_ASSERT(a_load_no_result, clock, reset, (pipe_adv && s0_load) |=> !s1_vld_ff, "load beat entered the product stage")
   `MM4_ASSERT(a_stall_freezes, clock, reset, (out_vld_ff && !rsp.ready) |=> ($stable(s2_vld_ff) && $stable(s1_vld_ff)), "pipeline moved while output stalled")

endmodule

`default_nettype wire

/* hw/rtl/matrix4_multiply_unit.sv */
// ----------------------------------------------------------------------------
// matrix4_multiply_unit
// 4x4 signed fixed-point matrix product, one product row per multiply beat.
//
// req: one beat per row. req_type low loads row row_index of the held B
//    matrix and returns nothing; req_type high multiplies the carried row of
//    A by B and returns one rsp beat with the product row.
// rsp: out_row echoes row_index; each element is the exact dot product
//    shifted right (floor) by FRAC_BITS and clipped to 32 bits; saturated is
//    set when any element was clipped.
// Throughput: one beat per cycle on req and rsp, loads and multiplies mixed,
//    while rsp.ready is high. A multiply beat passes the input register,
//    queue, operand stage, 16 multipliers, column adders, shift and clip into
//    the output register. Loads take effect for every later beat.
// Stall: while a result waits on rsp.ready it holds and the back pipeline
//    freezes; the queue of QUEUE_DEPTH beats keeps req.ready up until full.
// Reset: synchronous; clears B to all zeros and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_multiply_unit #(
   parameter int FRAC_BITS   = mm4_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = mm4_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mm4_req_if.sink   req,
   mm4_rsp_if.source rsp
);
   import mm4_pkg::*;

   logic      push_vld;
   logic      push_rdy;
   entry_type push_data;
   logic      pop_vld;
   logic      pop_rdy;
   entry_type pop_data;

   mm4_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push_vld  (push_vld),
      .push_rdy  (push_rdy),
      .push_data (push_data)
   );

   mm4_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_rdy  (push_rdy),
      .push_data (push_data),
      .pop_vld   (pop_vld),
      .pop_rdy   (pop_rdy),
      .pop_data  (pop_data)
   );

   mm4_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_vld  (pop_vld),
      .pop_rdy  (pop_rdy),
      .pop_data (pop_data),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

/* dv/matrix4_multiply_unit_test.sv */
// ----------------------------------------------------------------------------
// matrix4_multiply_unit_test
// Drives load and multiply beats into the 4x4 Q16.16 product unit, takes each
// product row from the table or predicts it from a local copy of B, and checks
// each response beat field by field. A short directed table comes first, then
// random load/multiply sequences under bursty input and a stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_multiply_unit_test;
   import mm4_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int RAND_ITEMS   = 2000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;

   localparam logic [DATA_W-1:0] ONE  = 32'h0001_0000;
   localparam logic [DATA_W-1:0] NEG1 = 32'hFFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_HI = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SUM_LO = -66'sd2147483648;

   typedef logic [DIM-1:0][DATA_W-1:0] quad_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      quad_type         e;
      logic             sat;
   } prod_row_type;

   typedef struct {
      op_type           op;
      logic [ROW_W-1:0] row;
      quad_type         a;
      bit               typed;
      prod_row_type     want;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mm4_req_if req_ch ();
   mm4_rsp_if rsp_ch ();

   matrix4_multiply_unit #(.FRAC_BITS(FRAC)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // local copy of B, indexed [row][col]
   quad_type [DIM-1:0] b_matrix;
   prod_row_type       pending_rows[$];
   stim_type           directed_tbl[$];
   int                 beats_sent = 0;
   int                 fail_count = 0;
   int                 burst_left = 0;
   int                 cycle_count = 0;

   function automatic prod_row_type multiply_row(logic [ROW_W-1:0] row, quad_type a);
      prod_row_type             r;
      logic signed [SUM_W-1:0]  acc;
      logic signed [SUM_W-1:0]  shifted;
      logic signed [PROD_W-1:0] p;
      r.row = row;
      r.sat = 1'b0;
      for (int c = 0; c < DIM; c++) begin
         acc = '0;
         for (int k = 0; k < DIM; k++) begin
            p = $signed(a[k]) * $signed(b_matrix[k][c]);
            acc = acc + p;
         end
         shifted = acc >>> FRAC;
         if (shifted > SUM_HI) begin
            r.e[c] = ELEM_MAX;
            r.sat = 1'b1;
         end else if (shifted < SUM_LO) begin
            r.e[c] = ELEM_MIN;
            r.sat = 1'b1;
         end else begin
            r.e[c] = shifted[DATA_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic stim_type stim(op_type op, logic [ROW_W-1:0] row,
                                     logic [DATA_W-1:0] a0, a1, a2, a3,
                                     bit typed = 1'b0,
                                     logic [DATA_W-1:0] x0 = '0, x1 = '0, x2 = '0,
                                     logic [DATA_W-1:0] x3 = '0, logic xsat = 1'b0);
      stim_type s;
      s.op = op;
      s.row = row;
      s.a = {a3, a2, a1, a0};
      s.typed = typed;
      s.want.row = row;
      s.want.e = {x3, x2, x1, x0};
      s.want.sat = xsat;
      return s;
   endfunction

   function automatic logic [DATA_W-1:0] pick_elem(int mode);
      int m;
      m = (mode == 3) ? $urandom_range(0, 2) : mode;
      case (m)
         0: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
         1: begin
            case ($urandom_range(0, 5))
               0: return ELEM_MAX;
               1: return ELEM_MIN;
               2: return '0;
               3: return 32'd1;
               4: return NEG1;
               default: return ONE;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic quad_type pick_quad(int mode);
      quad_type q;
      for (int i = 0; i < DIM; i++) q[i] = pick_elem(mode);
      return q;
   endfunction

   task automatic send_beat(stim_type s);
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= s.op;
      req_ch.row_index <= s.row;
      req_ch.in_e0     <= s.a[0];
      req_ch.in_e1     <= s.a[1];
      req_ch.in_e2     <= s.a[2];
      req_ch.in_e3     <= s.a[3];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (s.op == OP_LOAD)
         b_matrix[s.row] = s.a;
      else
         pending_rows.push_back(s.typed ? s.want : multiply_row(s.row, s.a));
      beats_sent++;
      // bursts with random gaps; a zero gap keeps valid up
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 7);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      prod_row_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rows.size() == 0) begin
            $error("response beat with no product row pending");
            fail_count++;
         end else begin
            want = pending_rows.pop_front();
            check_field("out_row", 32'(want.row), 32'(rsp_ch.out_row));
            check_field("out_e0", want.e[0], rsp_ch.out_e0);
            check_field("out_e1", want.e[1], rsp_ch.out_e1);
            check_field("out_e2", want.e[2], rsp_ch.out_e2);
            check_field("out_e3", want.e[3], rsp_ch.out_e3);
            check_field("saturated", 32'(want.sat), 32'(rsp_ch.saturated));
         end
      end
   end

   // receiver: random stall pattern, one long hold-off to back up the queue
   initial begin
      logic [7:0] pattern;
      int         phase_left;
      int         hold_left;
      int         pat_idx;
      bit         held;
      pattern = 8'hFF;
      phase_left = 0;
      hold_left = 0;
      pat_idx = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && beats_sent >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(16, 96);
               pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            phase_left--;
            rsp_ch.ready <= pattern[pat_idx % 8];
            pat_idx++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("matrix4_multiply_unit_test NOT OK");
      $finish;
   end

   initial begin
      int target;
      int mode;
      int n_loads;
      int n_muls;
      req_ch.valid = 1'b0;
      req_ch.req_type = OP_LOAD;
      req_ch.row_index = '0;
      req_ch.in_e0 = '0;
      req_ch.in_e1 = '0;
      req_ch.in_e2 = '0;
      req_ch.in_e3 = '0;
      b_matrix = '0;

      // multiply before any load: B is all zero
      directed_tbl.push_back(stim(OP_MUL, 2'd0, ELEM_MAX, ELEM_MIN, 32'd1, NEG1, 1'b1));
      directed_tbl.push_back(stim(OP_MUL, 2'd3, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1));
      // identity: rows pass through unchanged
      directed_tbl.push_back(stim(OP_LOAD, 2'd0, ONE, '0, '0, '0));
      directed_tbl.push_back(stim(OP_LOAD, 2'd1, '0, ONE, '0, '0));
      directed_tbl.push_back(stim(OP_LOAD, 2'd2, '0, '0, ONE, '0));
      directed_tbl.push_back(stim(OP_LOAD, 2'd3, '0, '0, '0, ONE));
      directed_tbl.push_back(stim(OP_MUL, 2'd1, ONE, 32'h0002_0000, 32'hFFFD_0000, ELEM_MAX,
                                  1'b1, ONE, 32'h0002_0000, 32'hFFFD_0000, ELEM_MAX, 1'b0));
      directed_tbl.push_back(stim(OP_MUL, 2'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                                  1'b1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b0));
      // clip high and low
      directed_tbl.push_back(stim(OP_LOAD, 2'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
      directed_tbl.push_back(stim(OP_MUL, 2'd0, ELEM_MAX, '0, '0, '0,
                                  1'b1, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1));
      directed_tbl.push_back(stim(OP_MUL, 2'd1, ELEM_MIN, '0, '0, '0,
                                  1'b1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1));
      // four largest products need the full sum width
      for (int r = 0; r < DIM; r++)
         directed_tbl.push_back(stim(OP_LOAD, 2'(r), ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
      directed_tbl.push_back(stim(OP_MUL, 2'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                                  1'b1, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1));
      directed_tbl.push_back(stim(OP_MUL, 2'd3, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
                                  1'b1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1));
      // shift floors toward minus infinity
      directed_tbl.push_back(stim(OP_LOAD, 2'd0, 32'd1, 32'd1, 32'd1, 32'd1));
      directed_tbl.push_back(stim(OP_MUL, 2'd1, NEG1, '0, '0, '0,
                                  1'b1, NEG1, NEG1, NEG1, NEG1, 1'b0));
      directed_tbl.push_back(stim(OP_MUL, 2'd2, 32'd1, '0, '0, '0, 1'b1));
      // mixed values, predicted
      directed_tbl.push_back(stim(OP_LOAD, 2'd2, 32'h0001_8000, 32'hFFFF_C000, 32'h7FFF_0000,
                                  32'h8000_0001));
      directed_tbl.push_back(stim(OP_MUL, 2'd0, 32'h0002_0000, 32'hFFF0_0000, 32'h1234_5678,
                                  32'h0000_0100));
      directed_tbl.push_back(stim(OP_LOAD, 2'd1, ONE, ONE, ONE, ONE));
      directed_tbl.push_back(stim(OP_LOAD, 2'd3, 32'h0000_8000, 32'hFFFF_8000, 32'h0003_0000,
                                  32'h0000_0001));
      directed_tbl.push_back(stim(OP_MUL, 2'd3, ONE, ONE, 32'hFFFF_0000, 32'h0001_8000));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_tbl[i]) send_beat(directed_tbl[i]);

      target = beats_sent + RAND_ITEMS;
      while (beats_sent < target) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 6) ? 0 : (mode < 8) ? 3 : 2;
         if ($urandom_range(0, 9) < 7) begin
            // load none, some or all of B, then a run of multiplies
            n_loads = $urandom_range(0, 4);
            for (int i = 0; i < n_loads; i++) begin
               stim_type s;
               s = stim(OP_LOAD, (n_loads == DIM) ? 2'(i) : 2'($urandom_range(0, 3)),
                        '0, '0, '0, '0);
               s.a = pick_quad(mode);
               send_beat(s);
            end
            n_muls = $urandom_range(1, 8);
            for (int i = 0; i < n_muls; i++) begin
               stim_type s;
               s = stim(OP_MUL, 2'($urandom_range(0, 3)), '0, '0, '0, '0);
               s.a = pick_quad(mode);
               send_beat(s);
            end
         end else begin
            stim_type s;
            s = stim(op_type'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), '0, '0, '0, '0);
            s.a = pick_quad(2);
            send_beat(s);
         end
      end
      // drop valid right at the last accepting edge so no beat repeats
      req_ch.valid <= 1'b0;

      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("matrix4_multiply_unit_test OK");
      else
         $display("matrix4_multiply_unit_test NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
